// ----- rtl/core/cvsm_pkg.sv -----
// shared types and constants for the cell voltage statistics monitor
// no dependencies; imported by every module of the block
package cvsm_pkg;

    localparam int unsigned MAX_CELLS   = 256;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned SUM_W   = 24;
    localparam int unsigned FAULT_W = 2;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [CNT_W-1:0]  CELLS_MAX = CNT_W'(MAX_CELLS);

    // register indexes on the configuration port
    localparam logic [2:0] REG_BROKEN = 3'd0;
    localparam logic [2:0] REG_OVER   = 3'd1;
    localparam logic [2:0] REG_UNDER  = 3'd2;
    localparam logic [2:0] REG_TOTAL  = 3'd3;
    localparam logic [2:0] REG_ENABLE = 3'd4;

    // fault indication codes
    localparam logic [FAULT_W-1:0] FAULT_OFF   = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_CLEAR = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_SET   = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [VOLT_W-1:0] lowest;
        logic [VOLT_W-1:0] highest;
        logic [CNT_W-1:0]  broken;
    } t_scan;

    typedef struct packed {
        logic [VOLT_W-1:0] broken_threshold;
        logic [VOLT_W-1:0] over_threshold;
        logic [VOLT_W-1:0] under_threshold;
        logic [CNT_W-1:0]  pack_cells;
        logic [1:0]        fault_enable;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]   valid_count;
        logic [VOLT_W-1:0]  lowest_voltage;
        logic [VOLT_W-1:0]  highest_voltage;
        logic [VOLT_W-1:0]  average_voltage;
        logic [SUM_W-1:0]   estimated_pack;
        logic               none_valid;
        logic [FAULT_W-1:0] over_fault;
        logic [FAULT_W-1:0] under_fault;
    } t_result;

endpackage

// ----- rtl/core/cell_voltage_statistics_monitor_top.sv -----
// cell voltage statistics monitor: takes one cell word per cycle while busy is low
// (start high). the word with last_cell set closes the scan, and one result comes
// out on o_done for a single cycle with valid count, lowest, highest, truncated
// average, estimated pack voltage, none_valid and the two fault codes.
// once the last cell is accepted, its summary is queued and the back end runs a
// bit-serial divide, then saturate, multiply and add steps when at least one cell is
// valid, and goes straight to the add step when no cell is valid. cells stream at one
// per cycle while busy is low; a two-entry summary queue lets the next scan run while
// the divider works, and busy rises only when both entries are taken.
// the receiver cannot stall: each result is shown once and must be taken.
// reset (synchronous, active low) loads register defaults, clears running
// statistics, empties the queue and aborts any result in progress.
// apb registers at 4*i: broken_threshold, over_threshold, under_threshold,
// pack cell count, fault_enable; write only while no scan is pending.
// depends on cvsm_pkg, cvsm_front, cvsm_queue, cvsm_back
module cell_voltage_statistics_monitor_top #(
    parameter int unsigned P_MAX_CELLS   = cvsm_pkg::MAX_CELLS,
    parameter int unsigned P_QUEUE_DEPTH = cvsm_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cvsm_pkg::VOLT_W-1:0]   i_cell_voltage,
    input  logic                          i_last_cell,
    output logic                          o_done,
    output logic [cvsm_pkg::CNT_W-1:0]    o_valid_count,
    output logic [cvsm_pkg::VOLT_W-1:0]   o_lowest_voltage,
    output logic [cvsm_pkg::VOLT_W-1:0]   o_highest_voltage,
    output logic [cvsm_pkg::VOLT_W-1:0]   o_average_voltage,
    output logic [cvsm_pkg::SUM_W-1:0]    o_estimated_pack,
    output logic                          o_none_valid,
    output logic [cvsm_pkg::FAULT_W-1:0]  o_over_fault,
    output logic [cvsm_pkg::FAULT_W-1:0]  o_under_fault,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cvsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [cvsm_pkg::DATA_W-1:0]   pwdata,
    output logic [cvsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import cvsm_pkg::*;

    t_cfg       r_cfg;
    t_scan      push_scan;
    t_scan      head;
    t_result    result;
    logic       accept;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.broken_threshold <= 16'd5000;
            r_cfg.over_threshold   <= 16'd42000;
            r_cfg.under_threshold  <= 16'd28000;
            r_cfg.pack_cells       <= 9'd256;
            r_cfg.fault_enable     <= 2'd3;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BROKEN: r_cfg.broken_threshold <= pwdata[VOLT_W-1:0];
                REG_OVER:   r_cfg.over_threshold   <= pwdata[VOLT_W-1:0];
                REG_UNDER:  r_cfg.under_threshold  <= pwdata[VOLT_W-1:0];
                REG_TOTAL:  r_cfg.pack_cells       <= pwdata[CNT_W-1:0];
                REG_ENABLE: r_cfg.fault_enable     <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BROKEN: prdata = {{(DATA_W-VOLT_W){1'b0}}, r_cfg.broken_threshold};
            REG_OVER:   prdata = {{(DATA_W-VOLT_W){1'b0}}, r_cfg.over_threshold};
            REG_UNDER:  prdata = {{(DATA_W-VOLT_W){1'b0}}, r_cfg.under_threshold};
            REG_TOTAL:  prdata = {{(DATA_W-CNT_W){1'b0}}, r_cfg.pack_cells};
            REG_ENABLE: prdata = {{(DATA_W-2){1'b0}}, r_cfg.fault_enable};
            default:    prdata = '0;
        endcase
    end

    assign busy   = q_full;
    assign accept = start & ~busy;

    cvsm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_cell_voltage     (i_cell_voltage),
        .i_last_cell        (i_last_cell),
        .i_broken_threshold (r_cfg.broken_threshold),
        .o_push             (push),
        .o_scan             (push_scan)
    );

    cvsm_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_scan),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cvsm_back #(
        .P_MAX_CELLS (P_MAX_CELLS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .i_cfg    (r_cfg),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (result)
    );

    assign o_valid_count     = result.valid_count;
    assign o_lowest_voltage  = result.lowest_voltage;
    assign o_highest_voltage = result.highest_voltage;
    assign o_average_voltage = result.average_voltage;
    assign o_estimated_pack  = result.estimated_pack;
    assign o_none_valid      = result.none_valid;
    assign o_over_fault      = result.over_fault;
    assign o_under_fault     = result.under_fault;

endmodule

// ----- rtl/core/cvsm_front.sv -----
// front end: classifies each cell word and keeps running min, max, sum, broken count
// depends on cvsm_pkg; pushes one scan summary per last cell
module cvsm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [15:0]            i_cell_voltage,
    input  logic                   i_last_cell,
    input  logic [15:0]            i_broken_threshold,
    output logic                   o_push,
    output cvsm_pkg::t_scan        o_scan
);
    import cvsm_pkg::*;

    t_scan               r_run;
    t_scan               n_run;
    logic [SUM_W:0]      sum_ext;
    logic                broken;

    always_comb begin
        n_run   = r_run;
        broken  = (i_cell_voltage <= i_broken_threshold);
        sum_ext = {1'b0, r_run.sum} + {{(SUM_W+1-VOLT_W){1'b0}}, i_cell_voltage};
        if (broken) begin
            if (r_run.broken != CNT_MAX) begin
                n_run.broken = r_run.broken + 1'b1;
            end
        end else begin
            if (i_cell_voltage < r_run.lowest) begin
                n_run.lowest = i_cell_voltage;
            end
            if (i_cell_voltage > r_run.highest) begin
                n_run.highest = i_cell_voltage;
            end
            n_run.sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        end
    end

    assign o_scan = n_run;
    assign o_push = i_accept & i_last_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_cell)) begin
            r_run.sum     <= '0;
            r_run.lowest  <= VOLT_MAX;
            r_run.highest <= '0;
            r_run.broken  <= '0;
        end else if (i_accept) begin
            r_run <= n_run;
        end
    end

endmodule

// ----- rtl/core/cvsm_queue.sv -----
// small fifo of finished scan summaries between front and back
// depends on cvsm_pkg
module cvsm_queue #(
    parameter int unsigned P_DEPTH = cvsm_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  cvsm_pkg::t_scan        i_data,
    input  logic                   i_pop,
    output cvsm_pkg::t_scan        o_head,
    output logic                   o_empty,
    output logic                   o_full
);
    import cvsm_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);

    t_scan              r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(P_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/cvsm_back.sv -----
// back end: valid count, bit-serial average divide, pack estimate and fault codes
// depends on cvsm_pkg; pops scan summaries from cvsm_queue
module cvsm_back #(
    parameter int unsigned P_MAX_CELLS = cvsm_pkg::MAX_CELLS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  cvsm_pkg::t_scan        i_head,
    input  cvsm_pkg::t_cfg         i_cfg,
    output logic                   o_pop,
    output logic                   o_done,
    output cvsm_pkg::t_result      o_result
);
    import cvsm_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
    localparam int unsigned PROD_W = VOLT_W + CNT_W;
    localparam logic [CNT_W-1:0] CELL_LIMIT = CNT_W'(P_MAX_CELLS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_MUL,
        ST_SUM
    } t_state;

    t_state              r_state;
    t_scan               r_scan;
    logic [CNT_W-1:0]    r_valid;
    logic [CNT_W-1:0]    r_missing;
    logic [CNT_W-1:0]    r_rem;
    logic [SUM_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [VOLT_W-1:0]   r_avg;
    logic [PROD_W-1:0]   r_prod;
    logic                r_done;
    t_result             r_result;

    logic [CNT_W-1:0]    total_c;
    logic [CNT_W-1:0]    valid_c;
    logic [CNT_W:0]      shifted;
    logic                fits;
    logic [SUM_W:0]      est_ext;

    always_comb begin
        total_c = (i_cfg.pack_cells > CELL_LIMIT) ? CELL_LIMIT : i_cfg.pack_cells;
        valid_c = (i_head.broken >= total_c) ? '0 : total_c - i_head.broken;
        // one quotient bit per cycle, restoring
        shifted = {r_rem, r_quo[SUM_W-1]};
        fits    = (shifted >= {1'b0, r_valid});
        est_ext = {1'b0, r_scan.sum} + r_prod;
    end

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign o_done   = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_scan    <= i_head;
                        r_valid   <= valid_c;
                        r_missing <= total_c - valid_c;
                        r_rem     <= '0;
                        r_quo     <= i_head.sum;
                        r_step    <= '0;
                        r_avg     <= '0;
                        r_prod    <= '0;
                        r_state   <= (valid_c == '0) ? ST_SUM : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= fits ? CNT_W'(shifted - {1'b0, r_valid}) : shifted[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], fits};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    r_avg   <= (|r_quo[SUM_W-1:VOLT_W]) ? VOLT_MAX : r_quo[VOLT_W-1:0];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= {{(PROD_W-VOLT_W){1'b0}}, r_avg} *
                               {{(PROD_W-CNT_W){1'b0}}, r_missing};
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_result.valid_count     <= r_valid;
                    r_result.lowest_voltage  <= r_scan.lowest;
                    r_result.highest_voltage <= r_scan.highest;
                    r_result.average_voltage <= r_avg;
                    r_result.none_valid      <= (r_valid == '0);
                    if (r_valid == '0) begin
                        r_result.estimated_pack <= '0;
                    end else begin
                        r_result.estimated_pack <= est_ext[SUM_W] ? SUM_MAX
                                                                  : est_ext[SUM_W-1:0];
                    end
                    if (!i_cfg.fault_enable[0]) begin
                        r_result.over_fault <= FAULT_OFF;
                    end else if (r_scan.highest > i_cfg.over_threshold) begin
                        r_result.over_fault <= FAULT_SET;
                    end else begin
                        r_result.over_fault <= FAULT_CLEAR;
                    end
                    // broken readings never count toward undervoltage
                    if (!i_cfg.fault_enable[1]) begin
                        r_result.under_fault <= FAULT_OFF;
                    end else if (r_scan.lowest < i_cfg.under_threshold &&
                                 r_scan.lowest > i_cfg.broken_threshold) begin
                        r_result.under_fault <= FAULT_SET;
                    end else begin
                        r_result.under_fault <= FAULT_CLEAR;
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
